### hw/rtl/qrs_pkg.sv
package qrs_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_NONE   = 2'd0;
    localparam status_t ST_DOUBLE = 2'd1;
    localparam status_t ST_TWO    = 2'd2;
    localparam status_t ST_AZERO  = 2'd3;

    typedef struct packed {
        status_t status;
        logic    neg;
    } root_ctl_t;

endpackage

### hw/rtl/qrs_disc.sv
module qrs_disc import qrs_pkg::*; #(
    parameter int WORD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [WORD_BITS-1:0]     coef_a,
    input  logic [WORD_BITS-1:0]     coef_b,
    input  logic [WORD_BITS-1:0]     coef_c,
    output logic                     out_valid,
    output logic [2*WORD_BITS+1:0]   disc,
    output status_t                  status,
    output logic                     a_neg,
    output logic [WORD_BITS-1:0]     a_mag,
    output logic [WORD_BITS-1:0]     b_val
);
    localparam int W  = WORD_BITS;
    localparam int DW = 2 * W + 2;

    logic [2:0]   valid_reg;
    logic         valid4_reg;

    logic [W-1:0] ma1_reg, mb1_reg, mc1_reg, b1_reg;
    logic         an1_reg, cn1_reg, az1_reg;

    logic [2*W-1:0] bb2_reg, ac2_reg;
    logic [2*W-1:0] bb2_next, ac2_next;
    logic [W-1:0]   ma2_reg, b2_reg;
    logic           an2_reg, sd2_reg, az2_reg;

    logic [DW-1:0]  d3_reg, d3_next;
    logic [DW:0]    diff3;
    logic [DW-1:0]  ac4, bbx;
    logic           ng3_reg, ng3_next;
    logic [W-1:0]   ma3_reg, b3_reg;
    logic           an3_reg, az3_reg;

    logic [DW-1:0]  d4_reg;
    logic [W-1:0]   ma4_reg, b4_reg;
    logic           an4_reg;
    status_t        st4_reg, st4_next;

    assign bb2_next = mb1_reg * mb1_reg;
    assign ac2_next = ma1_reg * mc1_reg;

    assign ac4   = {ac2_reg, 2'b00};
    assign bbx   = {2'b00, bb2_reg};
    assign diff3 = {1'b0, bbx} - {1'b0, ac4};

    always_comb
    begin
        if (sd2_reg)
        begin
            d3_next  = bbx + ac4;
            ng3_next = 1'b0;
        end
        else
        begin
            d3_next  = diff3[DW-1:0];
            ng3_next = diff3[DW];
        end
    end

    always_comb
    begin
        if (az3_reg)
            st4_next = ST_AZERO;
        else if (ng3_reg)
            st4_next = ST_NONE;
        else if (d3_reg == '0)
            st4_next = ST_DOUBLE;
        else
            st4_next = ST_TWO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            valid4_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg  <= {valid_reg[1:0], in_valid};
            valid4_reg <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma1_reg <= coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
            mb1_reg <= coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
            mc1_reg <= coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;
            b1_reg  <= coef_b;
            an1_reg <= coef_a[W-1];
            cn1_reg <= coef_c[W-1];
            az1_reg <= (coef_a == '0);

            bb2_reg <= bb2_next;
            ac2_reg <= ac2_next;
            ma2_reg <= ma1_reg;
            b2_reg  <= b1_reg;
            an2_reg <= an1_reg;
            sd2_reg <= an1_reg ^ cn1_reg;
            az2_reg <= az1_reg;

            d3_reg  <= d3_next;
            ng3_reg <= ng3_next;
            ma3_reg <= ma2_reg;
            b3_reg  <= b2_reg;
            an3_reg <= an2_reg;
            az3_reg <= az2_reg;

            d4_reg  <= d3_reg;
            st4_reg <= st4_next;
            ma4_reg <= ma3_reg;
            b4_reg  <= b3_reg;
            an4_reg <= an3_reg;
        end
    end

    assign out_valid = valid4_reg;
    assign disc      = d4_reg;
    assign status    = st4_reg;
    assign a_neg     = an4_reg;
    assign a_mag     = ma4_reg;
    assign b_val     = b4_reg;

endmodule

### hw/rtl/qrs_sqrt.sv
module qrs_sqrt #(
    parameter int ROOT_BITS = 33,
    parameter int SIDE_W    = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [2*ROOT_BITS-1:0]   radicand,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic [ROOT_BITS-1:0]     root,
    output logic [SIDE_W-1:0]        out_side
);
    localparam int SW = ROOT_BITS;
    localparam int DW = 2 * SW;
    localparam int RW = SW + 2;

    logic              valid_reg [0:SW-1];
    logic [DW-1:0]     d_reg     [0:SW-1];
    logic [RW-1:0]     rem_reg   [0:SW-1];
    logic [SW-1:0]     root_reg  [0:SW-1];
    logic [SIDE_W-1:0] side_reg  [0:SW-1];

    for (genvar i = 0; i < SW; i++)
    begin : g_stage
        logic              v_src;
        logic [DW-1:0]     d_src;
        logic [RW-1:0]     rem_src, rem_sh, trial;
        logic [SW-1:0]     root_src;
        logic [SIDE_W-1:0] side_src;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign d_src    = radicand;
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign v_src    = valid_reg[i-1];
            assign d_src    = d_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign root_src = root_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        assign rem_sh = {rem_src[RW-3:0], d_src[DW-1:DW-2]};
        assign trial  = {root_src, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[i]    <= d_src << 2;
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_src[SW-2:0], ge};
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign out_side  = side_reg[SW-1];

endmodule

### hw/rtl/qrs_div.sv
module qrs_div #(
    parameter int NUM_BITS = 49,
    parameter int DEN_BITS = 33,
    parameter int SIDE_W   = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_BITS-1:0]  dividend,
    input  logic [DEN_BITS-1:0]  divisor,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [NUM_BITS-1:0]  quotient,
    output logic [SIDE_W-1:0]    out_side
);
    localparam int N  = NUM_BITS;
    localparam int RW = DEN_BITS + 1;

    logic              valid_reg [0:N-1];
    logic [N-1:0]      num_reg   [0:N-1];
    logic [N-1:0]      q_reg     [0:N-1];
    logic [RW-1:0]     rem_reg   [0:N-1];
    logic [DEN_BITS-1:0] den_reg [0:N-1];
    logic [SIDE_W-1:0] side_reg  [0:N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic                v_src;
        logic [N-1:0]        num_src, q_src;
        logic [RW-1:0]       rem_src, rem_sh, den_x;
        logic [DEN_BITS-1:0] den_src;
        logic [SIDE_W-1:0]   side_src;
        logic                ge;

        if (i == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign num_src  = dividend;
            assign q_src    = '0;
            assign rem_src  = '0;
            assign den_src  = divisor;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign v_src    = valid_reg[i-1];
            assign num_src  = num_reg[i-1];
            assign q_src    = q_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        assign rem_sh = {rem_src[RW-2:0], num_src[N-1]};
        assign den_x  = {1'b0, den_src};
        assign ge     = (rem_sh >= den_x);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i]  <= num_src << 1;
                q_reg[i]    <= {q_src[N-2:0], ge};
                rem_reg[i]  <= ge ? (rem_sh - den_x) : rem_sh;
                den_reg[i]  <= den_src;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quotient  = q_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

### hw/rtl/quadratic_root_solver.sv
// Most of the pipeline is the bit-per-stage square root (WORD_BITS+1 stages)
// and divider (WORD_BITS+FRAC_BITS+1).
// Throughput: one coefficient transfer per cycle; the whole pipeline holds while
// a finished result is stalled at the output register.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        coef_valid,
    output logic                        coef_stall,
    input  logic signed [WORD_BITS-1:0] coef_a,
    input  logic signed [WORD_BITS-1:0] coef_b,
    input  logic signed [WORD_BITS-1:0] coef_c,
    output logic                        root_valid,
    input  logic                        root_stall,
    output status_t                     root_status,
    output logic signed [WORD_BITS-1:0] root_low,
    output logic signed [WORD_BITS-1:0] root_high,
    output logic                        saturated
);
    localparam int W   = WORD_BITS;
    localparam int SW  = W + 1;
    localparam int DW  = 2 * W + 2;
    localparam int NW  = W + 2;
    localparam int DVW = W + 1 + FRAC_BITS;
    localparam int SDW = 2 * W + 3;
    localparam logic [DVW-1:0] HALF = {{(DVW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam logic [DVW-1:0] MAXP = HALF - 1'b1;

    logic en;

    logic          d_valid;
    logic [DW-1:0] d_disc;
    status_t       d_status;
    logic          d_aneg;
    logic [W-1:0]  d_amag, d_b;

    logic           s_valid;
    logic [SW-1:0]  s_root;
    logic [SDW-1:0] s_side;
    status_t        s_status;
    logic           s_aneg;
    logic [W-1:0]   s_amag, s_b;

    logic            n_valid_reg;
    logic [DVW-1:0]  n1_reg, n2_reg, n1_next, n2_next;
    logic [W:0]      den_reg;
    root_ctl_t       ctl1_reg, ctl1_next;
    logic            neg2_reg, neg2_next;
    logic [NW-1:0]   nb, sx, num1, num2;
    logic [W:0]      mag1, mag2;

    logic            q_valid;
    logic            q_valid_high;
    logic [DVW-1:0]  q1, q2;
    root_ctl_t       q_ctl;
    logic            q_neg2;

    logic            r_valid_reg;
    logic [W-1:0]    r1_reg, r2_reg, r1_next, r2_next;
    logic            rsat_reg, sat1, sat2;
    status_t         rst_reg;

    logic            out_valid_reg;
    status_t         out_status_reg, out_status_next;
    logic [W-1:0]    out_low_reg, out_high_reg, out_low_next, out_high_next;
    logic            out_sat_reg, out_sat_next;

    assign en         = !(out_valid_reg && root_stall);
    assign coef_stall = out_valid_reg && root_stall;

    qrs_disc #(.WORD_BITS(W)) u_disc (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (coef_valid),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .coef_c   (coef_c),
        .out_valid(d_valid),
        .disc     (d_disc),
        .status   (d_status),
        .a_neg    (d_aneg),
        .a_mag    (d_amag),
        .b_val    (d_b)
    );

    qrs_sqrt #(.ROOT_BITS(SW), .SIDE_W(SDW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid),
        .radicand (d_disc),
        .in_side  ({d_status, d_aneg, d_amag, d_b}),
        .out_valid(s_valid),
        .root     (s_root),
        .out_side (s_side)
    );

    assign {s_status, s_aneg, s_amag, s_b} = s_side;

    always_comb
    begin
        nb   = '0 - {{2{s_b[W-1]}}, s_b};
        sx   = {1'b0, s_root};
        num1 = nb - sx;
        num2 = nb + sx;
        mag1 = num1[NW-1] ? (W+1)'('0 - num1) : num1[W:0];
        mag2 = num2[NW-1] ? (W+1)'('0 - num2) : num2[W:0];
        n1_next = DVW'(mag1) << FRAC_BITS;
        n2_next = DVW'(mag2) << FRAC_BITS;
        ctl1_next.status = s_status;
        ctl1_next.neg    = num1[NW-1] ^ s_aneg;
        neg2_next        = num2[NW-1] ^ s_aneg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            den_reg  <= {s_amag, 1'b0};
            ctl1_reg <= ctl1_next;
            neg2_reg <= neg2_next;
        end
    end

    qrs_div #(.NUM_BITS(DVW), .DEN_BITS(W + 1), .SIDE_W($bits(root_ctl_t))) u_div_low (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n_valid_reg),
        .dividend (n1_reg),
        .divisor  (den_reg),
        .in_side  (ctl1_reg),
        .out_valid(q_valid),
        .quotient (q1),
        .out_side (q_ctl)
    );

    qrs_div #(.NUM_BITS(DVW), .DEN_BITS(W + 1), .SIDE_W(1)) u_div_high (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (n_valid_reg),
        .dividend (n2_reg),
        .divisor  (den_reg),
        .in_side  (neg2_reg),
        .out_valid(q_valid_high),
        .quotient (q2),
        .out_side (q_neg2)
    );

    always_comb
    begin
        sat1 = 1'b0;
        sat2 = 1'b0;
        if (q_ctl.neg)
        begin
            if (q1 > HALF)
            begin
                r1_next = {1'b1, {(W-1){1'b0}}};
                sat1    = 1'b1;
            end
            else
                r1_next = '0 - q1[W-1:0];
        end
        else
        begin
            if (q1 > MAXP)
            begin
                r1_next = {1'b0, {(W-1){1'b1}}};
                sat1    = 1'b1;
            end
            else
                r1_next = q1[W-1:0];
        end
        if (q_neg2)
        begin
            if (q2 > HALF)
            begin
                r2_next = {1'b1, {(W-1){1'b0}}};
                sat2    = 1'b1;
            end
            else
                r2_next = '0 - q2[W-1:0];
        end
        else
        begin
            if (q2 > MAXP)
            begin
                r2_next = {1'b0, {(W-1){1'b1}}};
                sat2    = 1'b1;
            end
            else
                r2_next = q2[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (en)
            r_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg   <= r1_next;
            r2_reg   <= r2_next;
            rsat_reg <= sat1 | sat2;
            rst_reg  <= q_ctl.status;
        end
    end

    always_comb
    begin
        out_status_next = rst_reg;
        if (rst_reg == ST_NONE || rst_reg == ST_AZERO)
        begin
            out_low_next  = '0;
            out_high_next = '0;
            out_sat_next  = 1'b0;
        end
        else
        begin
            out_sat_next = rsat_reg;
            if ($signed(r1_reg) < $signed(r2_reg))
            begin
                out_low_next  = r1_reg;
                out_high_next = r2_reg;
            end
            else
            begin
                out_low_next  = r2_reg;
                out_high_next = r1_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_status_reg <= out_status_next;
            out_low_reg    <= out_low_next;
            out_high_reg   <= out_high_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    assign root_valid  = out_valid_reg;
    assign root_status = out_status_reg;
    assign root_low    = out_low_reg;
    assign root_high   = out_high_reg;
    assign saturated   = out_sat_reg;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && (root_status == ST_NONE || root_status == ST_AZERO)
        |-> root_low == '0 && root_high == '0 && !saturated)
        else $error("no-root result carries nonzero data");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid |-> root_low <= root_high)
        else $error("roots out of order");

    a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_status == ST_DOUBLE |-> root_low == root_high)
        else $error("double root with unequal values");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        root_valid && root_stall |=> root_valid && $stable(root_low) && $stable(root_high))
        else $error("stalled result changed");

    a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid == q_valid_high)
        else $error("divider lanes out of step");

endmodule

### tb/sv/quadratic_root_solver_test.sv
module quadratic_root_solver_test;
    import qrs_pkg::*;

    typedef struct {
        status_t            st;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               sat;
    } roots_t;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        bit                 typed;
        roots_t             want;
    } coef_row_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam logic signed [31:0] MAXW = 32'sh7fffffff;
    localparam logic signed [31:0] MINW = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    logic               clk;
    logic               rst_n;
    logic               coef_valid;
    logic               coef_stall;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic               root_valid;
    logic               root_stall;
    status_t            root_status;
    logic signed [31:0] root_low;
    logic signed [31:0] root_high;
    logic               saturated;

    roots_t pending_roots[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_request;
    int     error_count;
    int     quiet_cycles;

    quadratic_root_solver i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .root_valid (root_valid),
        .root_stall (root_stall),
        .root_status(root_status),
        .root_low   (root_low),
        .root_high  (root_high),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [31:0] scale_root(input logic signed [127:0] num,
                                                      input logic signed [127:0] aw,
                                                      inout logic sat);
        logic         neg;
        logic [127:0] mag_n;
        logic [127:0] mag_a;
        logic [127:0] q;
        neg   = (num < 0) != (aw < 0);
        mag_n = (num < 0) ? -num : num;
        mag_a = (aw < 0) ? -aw : aw;
        q     = (mag_n << 16) / (mag_a << 1);
        if (neg)
        begin
            if (q > 128'h80000000)
            begin
                sat = 1'b1;
                return MINW;
            end
            return -$signed(q[31:0]);
        end
        if (q > 128'h7fffffff)
        begin
            sat = 1'b1;
            return MAXW;
        end
        return q[31:0];
    endfunction

    function automatic roots_t solve_roots(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic signed [31:0] c);
        roots_t              r;
        logic signed [127:0] aw;
        logic signed [127:0] bw;
        logic signed [127:0] cw;
        logic signed [127:0] disc;
        logic [127:0]        s;
        logic [127:0]        t;
        logic signed [31:0]  r1;
        logic signed [31:0]  r2;
        logic                sat;
        r   = '{ST_NONE, 32'sd0, 32'sd0, 1'b0};
        sat = 1'b0;
        if (a == 0)
        begin
            r.st = ST_AZERO;
            return r;
        end
        aw   = a;
        bw   = b;
        cw   = c;
        disc = bw * bw - 4 * aw * cw;
        if (disc < 0)
            return r;
        if (disc == 0)
        begin
            r1   = scale_root(-bw, aw, sat);
            r2   = r1;
            r.st = ST_DOUBLE;
        end
        else
        begin
            s = 0;
            for (int i = 40; i >= 0; i--)
            begin
                t = s | (128'd1 << i);
                if (t * t <= disc)
                    s = t;
            end
            r1   = scale_root(-bw - $signed(s), aw, sat);
            r2   = scale_root(-bw + $signed(s), aw, sat);
            r.st = ST_TWO;
        end
        r.lo  = (r1 < r2) ? r1 : r2;
        r.hi  = (r1 < r2) ? r2 : r1;
        r.sat = sat;
        return r;
    endfunction

    task automatic send_coefs(input logic signed [31:0] a, input logic signed [31:0] b,
                              input logic signed [31:0] c, input bit typed,
                              input roots_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            coef_valid <= 1'b0;
            @(negedge clk);
        end
        coef_valid <= 1'b1;
        coef_a     <= a;
        coef_b     <= b;
        coef_c     <= c;
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
        pending_roots.push_back(typed ? want : solve_roots(a, b, c));
    endtask

    task automatic send_random;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        int                 p;
        int                 q;
        int                 k;
        int                 r1;
        int                 r2;
        roots_t             none;
        none = '{ST_NONE, 32'sd0, 32'sd0, 1'b0};
        a = $urandom;
        b = $urandom;
        c = $urandom;
        case ($urandom_range(9))
            0: a = 0;
            1, 2: ;
            3, 4, 5:
            begin
                a = $signed(a) >>> 11;
                b = $signed(b) >>> 11;
                c = $signed(c) >>> 11;
            end
            6, 7:
            begin
                p = $urandom_range(3000, 1);
                q = $urandom_range(3000, 1);
                a = p * p;
                c = q * q;
                b = 2 * p * q;
                if ($urandom_range(1))
                    b = -b;
                if ($urandom_range(1))
                begin
                    a = -a;
                    c = -c;
                end
            end
            default:
            begin
                k  = $urandom_range(400, 1) - 200;
                r1 = $urandom_range(200) - 100;
                r2 = $urandom_range(200) - 100;
                if (k == 0)
                    k = 1;
                a = k;
                b = -k * (r1 + r2);
                c = k * r1 * r2;
            end
        endcase
        send_coefs(a, b, c, 1'b0, none);
    endtask

    initial
    begin
        root_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                root_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            root_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && root_valid && !root_stall)
        begin
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected result status %0d low %0d high %0d sat %0d",
                         $time, root_status, root_low, root_high, saturated);
                error_count++;
            end
            else
            begin
                want = pending_roots.pop_front();
                if (root_status !== want.st)
                begin
                    $display("%0t: root_status expected %0d actual %0d",
                             $time, want.st, root_status);
                    error_count++;
                end
                if (root_low !== want.lo)
                begin
                    $display("%0t: root_low expected %0d actual %0d",
                             $time, want.lo, root_low);
                    error_count++;
                end
                if (root_high !== want.hi)
                begin
                    $display("%0t: root_high expected %0d actual %0d",
                             $time, want.hi, root_high);
                    error_count++;
                end
                if (saturated !== want.sat)
                begin
                    $display("%0t: saturated expected %0d actual %0d",
                             $time, want.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((coef_valid && !coef_stall) || (root_valid && !root_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        coef_row_t rows[$];
        roots_t    none;
        none = '{ST_NONE, 32'sd0, 32'sd0, 1'b0};
        rows = '{
            '{32'sd0, 32'sd5, -32'sd7, 1'b1, '{ST_AZERO, 32'sd0, 32'sd0, 1'b0}},
            '{32'sd0, MINW, MAXW, 1'b1, '{ST_AZERO, 32'sd0, 32'sd0, 1'b0}},
            '{ONE, 32'sd0, ONE, 1'b1, '{ST_NONE, 32'sd0, 32'sd0, 1'b0}},
            '{ONE, -2 * ONE, ONE, 1'b1, '{ST_DOUBLE, ONE, ONE, 1'b0}},
            '{ONE, 32'sd0, -4 * ONE, 1'b1, '{ST_TWO, -2 * ONE, 2 * ONE, 1'b0}},
            '{32'sd1, MINW, 32'sd0, 1'b0, none},
            '{32'sd1, MAXW, 32'sd0, 1'b0, none},
            '{-32'sd1, MAXW, 32'sd1, 1'b0, none},
            '{MAXW, MAXW, MINW, 1'b0, none},
            '{MINW, MINW, MAXW, 1'b0, none},
            '{MINW, MAXW, MAXW, 1'b0, none},
            '{MAXW, MINW, MINW, 1'b0, none},
            '{MINW, 32'sd0, MINW, 1'b0, none},
            '{32'sd1, 32'sd2, 32'sd1, 1'b0, none},
            '{32'sd4, 32'sd4, 32'sd1, 1'b0, none},
            '{32'sd3, 32'sd7, 32'sd4, 1'b0, none},
            '{-ONE, ONE, 32'sd0, 1'b0, none},
            '{32'sd1, 32'sd0, MINW, 1'b0, none},
            '{-32'sd1, 32'sd0, MAXW, 1'b0, none},
            '{ONE, -32'sd1, 32'sd0, 1'b0, none}
        };
        rst_n          = 1'b0;
        coef_valid     = 1'b0;
        coef_a         = '0;
        coef_b         = '0;
        coef_c         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        error_count    = 0;
        quiet_cycles   = 0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].want);

        hold_request = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 27 : 0;
            recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 27 : 0;
            repeat (150)
                send_random();
        end
        @(negedge clk);
        coef_valid <= 1'b0;

        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (120)
            @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### quadratic_root_solver.f
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_disc.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver.sv
tb/sv/quadratic_root_solver_test.sv
